// ----- rtl/mlp_pkg.sv -----
// shared types, constants and modular helpers for the lagged prng
package mlp_pkg;

  localparam int DATA_W        = 31;
  localparam int DEF_RING_SIZE = 1597;
  localparam int DEF_SHORT_LAG = 7;

  // multiplier -(2^25 + 2^7) mod 2^31-1 is applied as two rotations
  localparam int ROT_HI = 25;
  localparam int ROT_LO = 7;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t MOD_PRIME = word_t'(32'h7fff_ffff);

  typedef struct packed {
    logic use_cur;
    logic use_lag;
  } mask_t;

  typedef struct packed {
    logic  cmd;
    logic  use_cur;
    logic  use_lag;
    word_t seed;
  } issue_t;

  typedef enum logic {
    CMD_GEN  = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  // end-around carry add, result in 0 .. MOD_PRIME (all ones stands for zero)
  function automatic word_t add_mod(word_t a, word_t b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W-1:0] + word_t'(s[DATA_W]);
  endfunction

  // times 2^k mod 2^31-1 is a rotate left
  function automatic word_t mul_pow2(word_t x, int k);
    logic [2*DATA_W-1:0] d;
    d = {x, x} << k;
    return d[2*DATA_W-1:DATA_W];
  endfunction

  // negate and return the canonical residue
  function automatic word_t neg_mod(word_t t);
    word_t r;
    r = MOD_PRIME - t;
    return (r == MOD_PRIME) ? '0 : r;
  endfunction

endpackage

// ----- rtl/mrg_lagged_prng_top.sv -----
// top level of the lagged multiple recursive prng over 2^31-1
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  s_tdata: seed_word, s_tuser: cmd
//   m_*       out   m_tvalid/m_tready  m_tdata: rand_value
//
// one item per cycle unless a lag hazard or a stalled output holds the input;
// a generate item is read from the ring on the edge that takes it, then goes
// through sum, rotate-add and negate into the output register
// the ring memory has two read ports and one write port, so the index and
// lag words of an item are read together in its accept cycle
// an item waits at the input while its lag entry is still in the three
// pipeline stages, which only happens when SHORT_LAG is below four
// a waiting result stalls the pipeline, which still takes items until full
// reset clears index and control at once; the ring needs no clearing pass,
// entries not yet written since reset read as zero
module mrg_lagged_prng_top #(
  parameter int RING_SIZE = mlp_pkg::DEF_RING_SIZE,
  parameter int SHORT_LAG = mlp_pkg::DEF_SHORT_LAG
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] seed_word, [31] zero fill
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [30:0] rand_value, [31] zero fill
);

  localparam int IDX_W = $clog2(RING_SIZE);

  logic               accept;
  logic               take;
  logic               hazard;
  logic [IDX_W-1:0]   cur_addr;
  logic [IDX_W-1:0]   lag_addr;
  mlp_pkg::mask_t     mask;
  mlp_pkg::issue_t    tag;
  mlp_pkg::word_t     rd_data_cur;
  mlp_pkg::word_t     rd_data_lag;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  mlp_pkg::word_t     wr_data;
  mlp_pkg::word_t     rand_value;

  assign s_tready = take && !hazard;
  assign accept   = s_tvalid && s_tready;

  assign tag.cmd     = s_tuser[0];
  assign tag.use_cur = mask.use_cur;
  assign tag.use_lag = mask.use_lag;
  assign tag.seed    = s_tdata[mlp_pkg::DATA_W-1:0];

  assign m_tdata = {1'b0, rand_value};

  mlp_addr_gen #(
    .RING_SIZE (RING_SIZE),
    .SHORT_LAG (SHORT_LAG)
  ) u_addr (
    .clk      (clk),
    .rst      (rst),
    .step     (accept),
    .cur_addr (cur_addr),
    .lag_addr (lag_addr),
    .mask     (mask)
  );

  mlp_ring_mem #(
    .RING_SIZE (RING_SIZE)
  ) u_ring (
    .clk         (clk),
    .rd_en       (accept),
    .rd_addr_cur (cur_addr),
    .rd_addr_lag (lag_addr),
    .rd_data_cur (rd_data_cur),
    .rd_data_lag (rd_data_lag),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  mlp_pipe #(
    .RING_SIZE (RING_SIZE)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .in_tag      (tag),
    .in_idx      (cur_addr),
    .lag_addr    (lag_addr),
    .rd_data_cur (rd_data_cur),
    .rd_data_lag (rd_data_lag),
    .take        (take),
    .hazard      (hazard),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (rand_value)
  );

endmodule

// ----- rtl/mlp_addr_gen.sv -----
// ring index, lag address and written-entry mask
module mlp_addr_gen #(
  parameter int RING_SIZE = mlp_pkg::DEF_RING_SIZE,
  parameter int SHORT_LAG = mlp_pkg::DEF_SHORT_LAG,
  localparam int IDX_W = $clog2(RING_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  output logic [IDX_W-1:0]    cur_addr,
  output logic [IDX_W-1:0]    lag_addr,
  output mlp_pkg::mask_t      mask
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_SIZE - 1);
  localparam logic [IDX_W-1:0] LAG  = IDX_W'(SHORT_LAG);
  localparam logic [IDX_W-1:0] BACK = IDX_W'(RING_SIZE - SHORT_LAG);

  logic [IDX_W-1:0] idx;
  logic             full;

  assign cur_addr = idx;
  assign lag_addr = (idx < LAG) ? idx + BACK : idx - LAG;

  // until the first wrap only entries below the index have been written
  assign mask.use_cur = full;
  assign mask.use_lag = full || (lag_addr < idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      full <= 1'b0;
    end else if (step) begin
      if (idx == LAST) begin
        idx  <= '0;
        full <= 1'b1;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/mlp_ring_mem.sv -----
// history ring: two registered read ports, one write port
module mlp_ring_mem #(
  parameter int RING_SIZE = mlp_pkg::DEF_RING_SIZE,
  localparam int IDX_W = $clog2(RING_SIZE)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr_cur,
  input  logic [IDX_W-1:0]    rd_addr_lag,
  output mlp_pkg::word_t      rd_data_cur,
  output mlp_pkg::word_t      rd_data_lag,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  mlp_pkg::word_t      wr_data
);

  mlp_pkg::word_t mem [RING_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_cur <= mem[rd_addr_cur];
      rd_data_lag <= mem[rd_addr_lag];
    end
  end

endmodule

// ----- rtl/mlp_pipe.sv -----
// arithmetic pipeline, write-back, lag interlock and output register
module mlp_pipe #(
  parameter int RING_SIZE = mlp_pkg::DEF_RING_SIZE,
  localparam int IDX_W = $clog2(RING_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  mlp_pkg::issue_t     in_tag,
  input  logic [IDX_W-1:0]    in_idx,
  input  logic [IDX_W-1:0]    lag_addr,
  input  mlp_pkg::word_t      rd_data_cur,
  input  mlp_pkg::word_t      rd_data_lag,
  output logic                take,
  output logic                hazard,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output mlp_pkg::word_t      wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mlp_pkg::word_t      out_data
);

  // stage 1: read data arrives with its tag
  logic               v1;
  mlp_pkg::issue_t    tag1;
  logic [IDX_W-1:0]   i1;
  // stage 2: sum of the two words (or seed)
  logic               v2;
  logic               cmd2;
  logic [IDX_W-1:0]   i2;
  mlp_pkg::word_t     s2;
  // stage 3: sum times 2^25 + 2^7 (or seed)
  logic               v3;
  logic               cmd3;
  logic [IDX_W-1:0]   i3;
  mlp_pkg::word_t     s3;

  logic               out_free;
  logic               leave3;
  logic               take3;
  logic               take2;
  mlp_pkg::word_t     opnd_cur;
  mlp_pkg::word_t     opnd_lag;
  mlp_pkg::word_t     s2_next;
  mlp_pkg::word_t     s3_next;
  mlp_pkg::word_t     gen_val;

  assign out_free = !out_valid || out_ready;
  assign leave3   = v3 && (cmd3 == mlp_pkg::CMD_LOAD || out_free);
  assign take3    = !v3 || leave3;
  assign take2    = !v2 || take3;
  assign take     = !v1 || take2;

  // lag entry still on its way to the ring
  assign hazard = (v1 && i1 == lag_addr) || (v2 && i2 == lag_addr) ||
                  (v3 && i3 == lag_addr);

  assign opnd_cur = tag1.use_cur ? rd_data_cur : '0;
  assign opnd_lag = tag1.use_lag ? rd_data_lag : '0;
  assign s2_next  = (tag1.cmd == mlp_pkg::CMD_LOAD) ? tag1.seed
                  : mlp_pkg::add_mod(opnd_cur, opnd_lag);
  assign s3_next  = (cmd2 == mlp_pkg::CMD_LOAD) ? s2
                  : mlp_pkg::add_mod(mlp_pkg::mul_pow2(s2, mlp_pkg::ROT_HI),
                                     mlp_pkg::mul_pow2(s2, mlp_pkg::ROT_LO));
  assign gen_val  = mlp_pkg::neg_mod(s3);

  assign wr_en   = leave3;
  assign wr_addr = i3;
  assign wr_data = (cmd3 == mlp_pkg::CMD_LOAD) ? s3 : gen_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        v1 <= in_valid;
      end
      if (take2) begin
        v2 <= v1;
      end
      if (take3) begin
        v3 <= v2;
      end
      if (v3 && cmd3 == mlp_pkg::CMD_GEN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag1 <= in_tag;
      i1   <= in_idx;
    end
    if (take2) begin
      cmd2 <= tag1.cmd;
      i2   <= i1;
      s2   <= s2_next;
    end
    if (take3) begin
      cmd3 <= cmd2;
      i3   <= i2;
      s3   <= s3_next;
    end
    if (v3 && cmd3 == mlp_pkg::CMD_GEN && out_free) begin
      out_data <= gen_val;
    end
  end

endmodule

// ----- rtl/mlp_checker.sv -----
// port-level checks for the lagged prng, bound to the top level
module mlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a result waiting for the sink stays put
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // values leave in canonical form, never the modulus itself
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[30:0] != 31'h7fff_ffff)
    else $error("non-canonical residue on output");

  // every result is pipelined, so none can show right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst, 1) || $past(rst, 2) || $past(rst, 3) |-> !m_tvalid)
    else $error("result appeared too soon after reset");

endmodule

bind mrg_lagged_prng_top mlp_checker u_mlp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the lagged multiple recursive prng
`timescale 1ns / 100ps

module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1690;

  // keeps its own copy of the ring and index and queues the values to come
  class mrg_predictor;
    localparam int RING = mlp_pkg::DEF_RING_SIZE;
    localparam int LAG = mlp_pkg::DEF_SHORT_LAG;
    localparam longint unsigned PRIME = 64'd2147483647;
    // -(2^25 + 2^7) taken mod 2^31-1
    localparam longint unsigned NEG_MULT = 64'd2113929087;

    mlp_pkg::word_t ring [RING];
    int unsigned pos;
    mlp_pkg::word_t expected_values [$];
    int results_checked;
    int mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      pos = 0;
      results_checked = 0;
      mismatches = 0;
    endfunction

    function void note_item(mlp_pkg::cmd_t c, mlp_pkg::word_t w);
      int unsigned lag;
      longint unsigned total;
      if (c == mlp_pkg::CMD_LOAD) begin
        ring[pos] = w;
      end else begin
        lag = (pos < LAG) ? pos + RING - LAG : pos - LAG;
        total = (64'(ring[lag]) + 64'(ring[pos])) % PRIME;
        ring[pos] = mlp_pkg::word_t'((total * NEG_MULT) % PRIME);
        expected_values.push_back(ring[pos]);
      end
      pos = (pos + 1 == RING) ? 0 : pos + 1;
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h want %h", results_checked, what, got, want);
      mismatches++;
    endtask

    task check_value(logic [31:0] tdata);
      mlp_pkg::word_t want;
      results_checked++;
      if (expected_values.size() == 0) begin
        report_mismatch("result with nothing expected", tdata, '0);
        return;
      end
      want = expected_values.pop_front();
      if (tdata[30:0] !== want)
        report_mismatch("rand_value", {1'b0, tdata[30:0]}, {1'b0, want});
      if (tdata[31] !== 1'b0) report_mismatch("zero fill", {31'b0, tdata[31]}, '0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  mrg_predictor ring_model = new();
  int idle_count = 0;
  int send_burst = 0;
  int recv_burst = 0;
  int stall_left = 0;
  bit held_off = 0;

  mrg_lagged_prng_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic mlp_pkg::word_t pick_seed();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return mlp_pkg::MOD_PRIME - 31'd1;
      2: return mlp_pkg::MOD_PRIME;
      default: return mlp_pkg::word_t'($urandom_range(0, 32'h7fff_fffe));
    endcase
  endfunction

  task automatic send_item(mlp_pkg::cmd_t c, mlp_pkg::word_t w);
    int gap;
    int r;
    gap = 0;
    if (send_burst > 0) begin
      send_burst--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) send_burst = $urandom_range(20, 80);
      else if (r >= 55) gap = idle_len();
    end
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, w};
    s_tuser <= c;
    do @(posedge clk); while (!s_tready);
  endtask

  // both handshakes are taken from values stable since the falling edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        ring_model.note_item(mlp_pkg::cmd_t'(s_tuser[0]), s_tdata[30:0]);
      if (m_tvalid && m_tready) ring_model.check_value(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_count <= 0;
      end else if (idle_count + 1 >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && ring_model.results_checked >= 300) begin
        held_off = 1;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (recv_burst > 0) begin
          recv_burst--;
        end else if ($urandom_range(0, 99) < 3) begin
          recv_burst = $urandom_range(30, 120);
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = idle_len();
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // generate on the cleared ring, lag reaching back to the top
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::MOD_PRIME - 31'd1);
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::MOD_PRIME - 31'd1);
    // all-ones seed, counts as zero
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::MOD_PRIME);
    send_item(mlp_pkg::CMD_LOAD, '0);
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::word_t'(31'h2aaa_aaaa));
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::word_t'(31'h5555_5555));
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::word_t'(31'h0000_0001));
    send_item(mlp_pkg::CMD_LOAD, mlp_pkg::word_t'(31'h4000_0000));
    // these read back the seeds seven places behind
    send_item(mlp_pkg::CMD_GEN, '0);
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::MOD_PRIME);
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::word_t'(31'h1234_5678));
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::word_t'(31'h2aaa_aaaa));
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::word_t'(31'h5555_5555));
    send_item(mlp_pkg::CMD_GEN, '0);
    send_item(mlp_pkg::CMD_GEN, mlp_pkg::MOD_PRIME - 31'd1);

    // enough items to step the index past the end of the ring
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 55) send_item(mlp_pkg::CMD_GEN, pick_seed());
      else send_item(mlp_pkg::CMD_LOAD, pick_seed());
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (ring_model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ring_model.pending() != 0)
      ring_model.report_mismatch("results never arrived", ring_model.pending(), '0);
    if (ring_model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
